// ----- hdl/mgic_pkg.sv -----
// shared types, widths and register indexes for the magnetometer iron compensation block
// no dependencies
package mgic_pkg;

    localparam int AXIS_W    = 24;
    localparam int COEF_W    = 21;
    localparam int COEF_FRAC = 18;
    localparam int DIFF_W    = AXIS_W + 1;
    localparam int PROD_W    = COEF_W + DIFF_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int SQ_W      = 2 * AXIS_W;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int CFG_W     = 3 * COEF_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_ZERO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_ONE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_TWO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd5;

    localparam logic [CFG_W-1:0] ROW_ZERO_RESET = CFG_W'(1) << COEF_FRAC;
    localparam logic [CFG_W-1:0] ROW_ONE_RESET  = CFG_W'(1) << (COEF_W + COEF_FRAC);
    localparam logic [CFG_W-1:0] ROW_TWO_RESET  = CFG_W'(1) << (2 * COEF_W + COEF_FRAC);

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(8388608);

    typedef struct packed {
        logic signed [AXIS_W-1:0] sample_x;
        logic signed [AXIS_W-1:0] sample_y;
        logic signed [AXIS_W-1:0] sample_z;
    } t_in;

    typedef struct packed {
        logic signed [AXIS_W-1:0] corrected_x;
        logic signed [AXIS_W-1:0] corrected_y;
        logic signed [AXIS_W-1:0] corrected_z;
        logic        [AXIS_W-1:0] magnitude;
        logic                     clipped;
    } t_out;

    typedef struct packed {
        logic [2:0][CFG_W-1:0]  rows;
        logic [2:0][AXIS_W-1:0] offs;
    } t_cfg;

    typedef struct packed {
        logic signed [AXIS_W-1:0] cx;
        logic signed [AXIS_W-1:0] cy;
        logic signed [AXIS_W-1:0] cz;
        logic                     clip;
    } t_side;

endpackage

// ----- hdl/mgic_cfg_regs.sv -----
// configuration register file: matrix rows and hard-iron offsets
// depends on mgic_pkg
module mgic_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mgic_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mgic_pkg::CFG_W-1:0]        i_cfg_data,
    output mgic_pkg::t_cfg                    o_cfg
);
    import mgic_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows[0] <= ROW_ZERO_RESET;
            r_cfg.rows[1] <= ROW_ONE_RESET;
            r_cfg.rows[2] <= ROW_TWO_RESET;
            r_cfg.offs    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROW_ZERO: r_cfg.rows[0] <= i_cfg_data;
                REG_ROW_ONE:  r_cfg.rows[1] <= i_cfg_data;
                REG_ROW_TWO:  r_cfg.rows[2] <= i_cfg_data;
                REG_OFFSET_X: r_cfg.offs[0] <= i_cfg_data[AXIS_W-1:0];
                REG_OFFSET_Y: r_cfg.offs[1] <= i_cfg_data[AXIS_W-1:0];
                REG_OFFSET_Z: r_cfg.offs[2] <= i_cfg_data[AXIS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/mgic_matrix.sv -----
// offset subtract, 3x3 matrix multiply, floor shift and saturation: three stages
// depends on mgic_pkg
module mgic_matrix (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mgic_pkg::t_in  i_in,
    input  mgic_pkg::t_cfg i_cfg,
    output logic           o_valid,
    output mgic_pkg::t_side o_side
);
    import mgic_pkg::*;

    logic                     r_v1, r_v2, r_v3;
    logic signed [DIFF_W-1:0] r_d [3];
    logic signed [PROD_W-1:0] r_p [3][3];
    t_side                    r_side;

    logic signed [AXIS_W-1:0] s_samp [3];
    logic signed [AXIS_W-1:0] n_c [3];
    logic                     n_clip;

    assign s_samp[0] = i_in.sample_x;
    assign s_samp[1] = i_in.sample_y;
    assign s_samp[2] = i_in.sample_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_d[j] <= DIFF_W'(s_samp[j]) - DIFF_W'($signed(i_cfg.offs[j]));
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_p[i][j] <= $signed(i_cfg.rows[i][COEF_W*j +: COEF_W]) * r_d[j];
            end
        end
        r_side.cx   <= n_c[0];
        r_side.cy   <= n_c[1];
        r_side.cz   <= n_c[2];
        r_side.clip <= n_clip;
    end

    always_comb begin
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] v;
        n_clip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            acc = ACC_W'(r_p[i][0]) + ACC_W'(r_p[i][1]) + ACC_W'(r_p[i][2]);
            v   = acc >>> COEF_FRAC;
            if (v > SAT_MAX) begin
                v      = SAT_MAX;
                n_clip = 1'b1;
            end else if (v < SAT_MIN) begin
                v      = SAT_MIN;
                n_clip = 1'b1;
            end
            n_c[i] = v[AXIS_W-1:0];
        end
    end

    assign o_valid = r_v3;
    assign o_side  = r_side;

endmodule

// ----- hdl/mgic_norm.sv -----
// squares of the saturated components and their sum: two stages
// depends on mgic_pkg
module mgic_norm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mgic_pkg::t_side i_side,
    output logic            o_valid,
    output logic [mgic_pkg::SQ_W-1:0] o_sum,
    output mgic_pkg::t_side o_side
);
    import mgic_pkg::*;

    logic                   r_v1, r_v2;
    logic signed [SQ_W-1:0] r_sq [3];
    logic        [SQ_W-1:0] r_sum;
    t_side                  r_side1, r_side2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq[0] <= i_side.cx * i_side.cx;
        r_sq[1] <= i_side.cy * i_side.cy;
        r_sq[2] <= i_side.cz * i_side.cz;
        r_side1 <= i_side;
        r_sum   <= $unsigned(r_sq[0]) + $unsigned(r_sq[1]) + $unsigned(r_sq[2]);
        r_side2 <= r_side1;
    end

    assign o_valid = r_v2;
    assign o_sum   = r_sum;
    assign o_side  = r_side2;

endmodule

// ----- hdl/mgic_isqrt.sv -----
// pipelined digit-by-digit integer square root, one root bit per stage
// depends on mgic_pkg
module mgic_isqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [mgic_pkg::SQ_W-1:0] i_sum,
    input  mgic_pkg::t_side i_side,
    output logic            o_valid,
    output logic [mgic_pkg::ROOT_W-1:0] o_root,
    output mgic_pkg::t_side o_side
);
    import mgic_pkg::*;

    logic              r_v    [ROOT_W];
    logic [SQ_W-1:0]   r_n    [ROOT_W];
    logic [ROOT_W-1:0] r_q    [ROOT_W];
    logic [REM_W-1:0]  r_r    [ROOT_W];
    t_side             r_side [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic              p_v;
        logic [SQ_W-1:0]   p_n;
        logic [ROOT_W-1:0] p_q;
        logic [REM_W-1:0]  p_r;
        t_side             p_side;
        logic [REM_W-1:0]  s_rem;
        logic [REM_W-1:0]  s_trial;
        logic              s_fit;

        if (g == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_n    = i_sum;
            assign p_q    = '0;
            assign p_r    = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[g-1];
            assign p_n    = r_n[g-1];
            assign p_q    = r_q[g-1];
            assign p_r    = r_r[g-1];
            assign p_side = r_side[g-1];
        end

        assign s_rem   = {p_r[REM_W-3:0], p_n[SQ_W-1 -: 2]};
        assign s_trial = REM_W'({p_q, 2'b01});
        assign s_fit   = s_rem >= s_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_n[g]    <= p_n << 2;
            r_q[g]    <= {p_q[ROOT_W-2:0], s_fit};
            r_r[g]    <= s_fit ? s_rem - s_trial : s_rem;
            r_side[g] <= p_side;
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_q[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

// ----- hdl/magnetometer_iron_compensation.sv -----
// throughput: one sample per cycle, o_busy is always low; 24 of the stages are the square root
// reset: synchronous active-low i_rst_n clears valid bits and loads identity matrix, zero offsets
// results cannot be held off, each is shown for one cycle only
// depends on mgic_pkg, mgic_cfg_regs, mgic_matrix, mgic_norm, mgic_isqrt
module magnetometer_iron_compensation (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  mgic_pkg::t_in                  i_in,
    output logic                           o_done,
    output mgic_pkg::t_out                 o_out,
    input  logic                           i_cfg_we,
    input  logic [mgic_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mgic_pkg::CFG_W-1:0]     i_cfg_data
);
    import mgic_pkg::*;

    t_cfg              s_cfg;
    logic              s_mat_v, s_norm_v, s_root_v;
    t_side             s_mat_side, s_norm_side, s_root_side;
    logic [SQ_W-1:0]   s_sum;
    logic [ROOT_W-1:0] s_root;

    assign o_busy = 1'b0;

    mgic_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (s_cfg)
    );

    mgic_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_in    (i_in),
        .i_cfg   (s_cfg),
        .o_valid (s_mat_v),
        .o_side  (s_mat_side)
    );

    mgic_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_mat_v),
        .i_side  (s_mat_side),
        .o_valid (s_norm_v),
        .o_sum   (s_sum),
        .o_side  (s_norm_side)
    );

    mgic_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_norm_v),
        .i_sum   (s_sum),
        .i_side  (s_norm_side),
        .o_valid (s_root_v),
        .o_root  (s_root),
        .o_side  (s_root_side)
    );

    assign o_done            = s_root_v;
    assign o_out.corrected_x = s_root_side.cx;
    assign o_out.corrected_y = s_root_side.cy;
    assign o_out.corrected_z = s_root_side.cz;
    assign o_out.magnitude   = AXIS_W'(s_root);
    assign o_out.clipped     = s_root_side.clip;

endmodule

// ----- tb/mgic_result_checker.sv -----
// result checker for magnetometer_iron_compensation: watches the sample, result and register ports,
// predicts each corrected vector and magnitude, and compares it with the block's result beats
// depends on mgic_pkg
module mgic_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  mgic_pkg::t_in                  i_in,
    input  logic                           i_done,
    input  mgic_pkg::t_out                 i_out,
    input  logic                           i_cfg_we,
    input  logic [mgic_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mgic_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_mismatches,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mgic_pkg::*;

    localparam longint CLIP_HI = 64'sd8388607;
    localparam longint CLIP_LO = -64'sd8388608;

    logic        [CFG_W-1:0]  mat_rows [3];
    logic signed [AXIS_W-1:0] iron_offs [3];
    t_out                     corrected_q [$];
    t_out                     want;
    int                       mismatch_count = 0;
    int                       pending_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    function automatic logic [AXIS_W-1:0] floor_root(logic [49:0] n);
        logic [25:0] root;
        logic [25:0] trial;
        logic [51:0] sq;
        root = '0;
        for (int b = 25; b >= 0; b--) begin
            trial = root | (26'd1 << b);
            sq = 52'(trial) * 52'(trial);
            if (sq <= 52'(n)) begin
                root = trial;
            end
        end
        return root[AXIS_W-1:0];
    endfunction

    function automatic t_out compensate(t_in s);
        logic signed [AXIS_W-1:0] raw [3];
        logic signed [DIFF_W-1:0] diff [3];
        logic signed [AXIS_W-1:0] comp [3];
        logic signed [COEF_W-1:0] k;
        logic signed [ACC_W-1:0]  acc;
        logic signed [ACC_W-1:0]  v;
        logic signed [49:0]       w;
        logic        [49:0]       energy;
        logic                     clip;
        t_out                     r;
        raw[0] = s.sample_x;
        raw[1] = s.sample_y;
        raw[2] = s.sample_z;
        clip   = 1'b0;
        energy = '0;
        for (int i = 0; i < 3; i++) begin
            diff[i] = raw[i] - iron_offs[i];
        end
        for (int i = 0; i < 3; i++) begin
            acc = '0;
            for (int j = 0; j < 3; j++) begin
                k   = mat_rows[i][j*COEF_W +: COEF_W];
                acc = acc + k * diff[j];
            end
            v = acc >>> COEF_FRAC;
            if (v > CLIP_HI) begin
                v    = ACC_W'(CLIP_HI);
                clip = 1'b1;
            end else if (v < CLIP_LO) begin
                v    = ACC_W'(CLIP_LO);
                clip = 1'b1;
            end
            comp[i] = v[AXIS_W-1:0];
            w       = comp[i];
            energy  = energy + 50'(w * w);
        end
        r.corrected_x = comp[0];
        r.corrected_y = comp[1];
        r.corrected_z = comp[2];
        r.magnitude   = floor_root(energy);
        r.clipped     = clip;
        return r;
    endfunction

    task automatic check_field(string name, logic [AXIS_W-1:0] exp_v, logic [AXIS_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %06h actual %06h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mat_rows[0] = ROW_ZERO_RESET;
            mat_rows[1] = ROW_ONE_RESET;
            mat_rows[2] = ROW_TWO_RESET;
            for (int i = 0; i < 3; i++) begin
                iron_offs[i] = '0;
            end
            corrected_q.delete();
        end else begin
            if (i_start && !i_busy) begin
                corrected_q = {corrected_q, compensate(i_in)};
            end
            if (i_done) begin
                if (corrected_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    mismatch_count++;
                end else begin
                    want = corrected_q.pop_front();
                    check_field("corrected_x", want.corrected_x, i_out.corrected_x);
                    check_field("corrected_y", want.corrected_y, i_out.corrected_y);
                    check_field("corrected_z", want.corrected_z, i_out.corrected_z);
                    check_field("magnitude", want.magnitude, i_out.magnitude);
                    check_field("clipped", AXIS_W'(want.clipped), AXIS_W'(i_out.clipped));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROW_ZERO: mat_rows[0] = i_cfg_data;
                    REG_ROW_ONE:  mat_rows[1] = i_cfg_data;
                    REG_ROW_TWO:  mat_rows[2] = i_cfg_data;
                    REG_OFFSET_X: iron_offs[0] = i_cfg_data[AXIS_W-1:0];
                    REG_OFFSET_Y: iron_offs[1] = i_cfg_data[AXIS_W-1:0];
                    REG_OFFSET_Z: iron_offs[2] = i_cfg_data[AXIS_W-1:0];
                    default: ;
                endcase
            end
        end
        pending_count = corrected_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// top of the magnetometer_iron_compensation testbench: clock, reset, register settings,
// directed and random sample beats with random idling, and the final verdict
// depends on mgic_pkg, mgic_result_checker and the block under test
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mgic_pkg::*;

    localparam int     PIPE_LAT     = 29;
    localparam int     PHASES       = 11;
    localparam int     PHASE_ITEMS  = 150;
    localparam longint TIMEOUT_NS   = 800000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [AXIS_W-1:0] AX_MAX = 24'h7FFFFF;
    localparam logic [AXIS_W-1:0] AX_MIN = 24'h800000;
    localparam logic [AXIS_W-1:0] AX_NEG = 24'hFFFFFF;
    localparam logic [AXIS_W-1:0] AX_ONE = 24'h000001;

    localparam logic [COEF_W-1:0] COEF_TOP = 21'h0FFFFF;
    localparam logic [COEF_W-1:0] COEF_BOT = 21'h100000;
    localparam logic [COEF_W-1:0] COEF_ONE = 21'h040000;
    localparam logic [COEF_W-1:0] COEF_NEG = 21'h1FFFFF;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_start    = 1'b0;
    t_in                  i_in       = '0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_busy;
    logic                 o_done;
    t_out                 o_out;
    int                   mismatches;
    int                   pending;
    int                   calm_left  = 0;
    logic                 calm       = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    magnetometer_iron_compensation u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_in       (i_in),
        .o_done     (o_done),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    mgic_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_in         (i_in),
        .i_done       (o_done),
        .i_out        (o_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [AXIS_W-1:0] pick_axis();
        logic [AXIS_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = AXIS_W'($urandom());
            4, 5, 6, 7: v = AXIS_W'(int'($urandom_range(0, 131072)) - 65536);
            default: begin
                case ($urandom_range(0, 4))
                    0: v = AX_MAX;
                    1: v = AX_MIN;
                    2: v = '0;
                    3: v = AX_ONE;
                    default: v = AX_NEG;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef(int style, bit diag);
        logic [COEF_W-1:0] k;
        case (style)
            0: begin
                if (diag) begin
                    k = COEF_W'(262144 + int'($urandom_range(0, 131072)) - 65536);
                end else begin
                    k = COEF_W'(int'($urandom_range(0, 65536)) - 32768);
                end
            end
            1: k = COEF_W'($urandom());
            default: begin
                case ($urandom_range(0, 5))
                    0: k = COEF_TOP;
                    1: k = COEF_BOT;
                    2: k = COEF_ONE;
                    3: k = COEF_NEG;
                    4: k = '0;
                    default: k = COEF_W'($urandom());
                endcase
            end
        endcase
        return k;
    endfunction

    function automatic t_cfg pick_setting(int style);
        t_cfg s;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s.rows[i][j*COEF_W +: COEF_W] = pick_coef(style, i == j);
            end
            case ($urandom_range(0, 2))
                0: s.offs[i] = AXIS_W'(int'($urandom_range(0, 8192)) - 4096);
                1: s.offs[i] = AXIS_W'($urandom());
                default: s.offs[i] = ($urandom_range(0, 1) == 0) ? AX_MAX : AX_MIN;
            endcase
        end
        return s;
    endfunction

    function automatic t_cfg make_setting(logic [COEF_W-1:0] diag, logic [COEF_W-1:0] rest,
                                          logic [AXIS_W-1:0] off);
        t_cfg s;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s.rows[i][j*COEF_W +: COEF_W] = (i == j) ? diag : rest;
            end
            s.offs[i] = off;
        end
        return s;
    endfunction

    // called at a falling edge, with the block idle
    task automatic load_setting(t_cfg s);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [CFG_W-1:0]     val;
        idx = '{REG_ROW_ZERO, REG_ROW_ONE, REG_ROW_TWO, REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z};
        i_cfg_we <= 1'b1;
        for (int i = 0; i < 6; i++) begin
            if (i < 3) begin
                val = s.rows[i];
            end else begin
                // bits above the offset width must be dropped
                val = {(CFG_W-AXIS_W)'({$urandom(), $urandom()}), s.offs[i-3]};
                if ($urandom_range(0, 1) == 0) begin
                    val[CFG_W-1:AXIS_W] = '0;
                end
            end
            i_cfg_idx  <= idx[i];
            i_cfg_data <= val;
            @(negedge i_clk);
            if (i == 2 && $urandom_range(0, 1) == 0) begin
                i_cfg_idx  <= ($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI;
                i_cfg_data <= CFG_W'({$urandom(), $urandom()});
                @(negedge i_clk);
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    // called at a falling edge; returns at a falling edge after the beat is taken
    task automatic push_sample(t_in s);
        int gap;
        gap = idle_gap();
        i_start <= 1'b1;
        i_in    <= s;
        // busy only moves on rising edges, so its value now holds for the coming edge
        while (o_busy) begin
            @(negedge i_clk);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (PIPE_LAT + 4) @(negedge i_clk);
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset matrix and offsets
        push_sample(t_in'{'0, '0, '0});
        push_sample(t_in'{AX_MAX, AX_MAX, AX_MAX});
        push_sample(t_in'{AX_MIN, AX_MIN, AX_MIN});
        push_sample(t_in'{AX_MAX, AX_MIN, '0});
        push_sample(t_in'{AX_NEG, AX_ONE, AX_NEG});
        drain();

        // identity with most negative offsets, difference beyond 24 bits
        load_setting(make_setting(COEF_ONE, '0, AX_MIN));
        push_sample(t_in'{AX_MAX, AX_MAX, AX_MAX});
        push_sample(t_in'{AX_MIN, AX_MIN, AX_MIN});
        push_sample(t_in'{'0, '0, '0});
        drain();

        // largest coefficients, largest offsets
        load_setting(make_setting(COEF_TOP, COEF_TOP, AX_MAX));
        push_sample(t_in'{AX_MIN, AX_MIN, AX_MIN});
        push_sample(t_in'{AX_MAX, AX_MAX, AX_MAX});
        push_sample(t_in'{'0, '0, '0});
        drain();

        // most negative coefficients
        load_setting(make_setting(COEF_BOT, COEF_BOT, '0));
        push_sample(t_in'{AX_MAX, AX_MAX, AX_MAX});
        push_sample(t_in'{AX_MIN, AX_MIN, AX_MIN});
        push_sample(t_in'{AX_ONE, '0, '0});
        drain();

        // tiny negative coefficients, floor of the shift
        load_setting(make_setting(COEF_NEG, COEF_NEG, '0));
        push_sample(t_in'{AX_ONE, AX_ONE, AX_ONE});
        push_sample(t_in'{AX_NEG, AX_NEG, AX_NEG});
        push_sample(t_in'{AX_MAX, '0, '0});
        drain();

        for (int p = 0; p < PHASES; p++) begin
            load_setting(pick_setting(p % 3));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (calm_left == 0) begin
                    calm_left = $urandom_range(10, 30);
                    calm      = ($urandom_range(0, 3) == 0);
                end
                calm_left--;
                push_sample(t_in'{pick_axis(), pick_axis(), pick_axis()});
                if ($urandom_range(0, 199) == 0) begin
                    drain();
                end
            end
            drain();
        end

        drain();
        repeat (PIPE_LAT + 8) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
